// ===== design/assert_macros.svh =====
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== design/pdh_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pdh_pkg
// Shared constants and command/status types for the pair distance histogram.
// ---------------------------------------------------------------------------
package pdh_pkg;
	localparam int FIELD_BITS  = 16;
	localparam int COORD_BITS  = 16;
	localparam int IDX_BITS    = 6;
	localparam int CNT_BITS    = 19;
	localparam int WIDTH_RESET = 500;
	localparam int ADDR_BITS   = 1;
	localparam logic [ADDR_BITS-1:0] REG_BUCKET_WIDTH = 1'b0;

	typedef struct packed {
		logic load;      // write incoming point
		logic clr_cnt;   // clear point count
		logic pair_init; // i=0, j=1
		logic pair_step; // issue pair, advance indices
		logic dump_init;
		logic dump_step;
	} pdh_cmd_t;

	typedef struct packed {
		logic pairs_none;  // fewer than two points
		logic pairs_done;  // current pair is the last
		logic pipe_empty;  // nothing in flight
		logic dump_last;   // last bucket being offered
	} pdh_sts_t;
endpackage

// ===== design/pdh_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pdh_in_if / pdh_out_if
// Valid/ready channels for points and bucket results.
// ---------------------------------------------------------------------------
interface pdh_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] x_coord;
	logic [15:0] y_coord;
	logic [15:0] z_coord;
	logic        last_point;
	modport source (output valid, x_coord, y_coord, z_coord, last_point, input ready);
	modport sink (input valid, x_coord, y_coord, z_coord, last_point, output ready);
endinterface

interface pdh_out_if;
	logic        valid;
	logic        ready;
	logic [5:0]  bucket_index;
	logic [18:0] bucket_count;
	logic        last_bucket;
	modport source (output valid, bucket_index, bucket_count, last_bucket, input ready);
	modport sink (input valid, bucket_index, bucket_count, last_bucket, output ready);
endinterface

// ===== design/pair_distance_histogram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pair_distance_histogram
// Histogram of distances over all point pairs of a loaded set.
// ---------------------------------------------------------------------------
// Points are taken one per cycle in the load state into a dual-copy point store
// (up to MAX_POINTS; extra points are dropped). The item marked last_point
// starts the pair walk: after a start state, one pair i<j enters the distance
// pipeline per cycle until the last pair is issued; the pipeline then drains
// (square, bit-serial root stages, divider stages, histogram update) and the
// first count is fetched. The HIST_BINS counts then leave one per cycle as the
// sink takes them, and the block is ready for the next set. Buckets past the
// last saturate into it; counts saturate at 524287; a bucket width of zero
// acts as one.
module pair_distance_histogram
	import pdh_pkg::*;
#(
	parameter int MAX_POINTS = 1024,
	parameter int HIST_BINS  = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	pdh_in_if.sink               pts,
	pdh_out_if.source            res,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS+1:0] paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	logic [15:0] width_q;
	pdh_cmd_t cmd;
	pdh_sts_t sts;
	logic out_valid;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= FIELD_BITS'(WIDTH_RESET);
		end else if (psel && penable && pwrite && paddr[ADDR_BITS+1:2] == REG_BUCKET_WIDTH) begin
			width_q <= pwdata[15:0];
		end
	end
	assign prdata = (paddr[ADDR_BITS+1:2] == REG_BUCKET_WIDTH) ? {16'd0, width_q} : 32'd0;

	pdh_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(pts.valid), .in_last(pts.last_point),
		.out_ready(res.ready), .sts(sts), .cmd(cmd), .out_valid(out_valid)
	);
	assign res.valid = out_valid;

	pdh_datapath #(
		.MAX_POINTS(MAX_POINTS), .HIST_BINS(HIST_BINS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .bucket_width(width_q),
		.pts(pts), .res(res)
	);
endmodule

// ===== design/pdh_isqrt.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pdh_isqrt
// Pipelined floor square root, one result bit per stage.
// ---------------------------------------------------------------------------
module pdh_isqrt #(
	parameter int IN_BITS  = 34,
	parameter int OUT_BITS = 17
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [IN_BITS-1:0]  radicand,
	output logic                out_valid,
	output logic [OUT_BITS-1:0] root
);
	localparam int RB = 2 * OUT_BITS;
	logic [OUT_BITS:0]  vld_q;
	logic [RB-1:0]      rem_q  [OUT_BITS+1];
	logic [OUT_BITS-1:0] res_q [OUT_BITS+1];

	always_comb begin
		vld_q[0] = in_valid;
		rem_q[0] = RB'(radicand);
		res_q[0] = '0;
	end

	for (genvar s = 0; s < OUT_BITS; s++) begin : g_stage
		localparam int B = OUT_BITS - 1 - s;
		logic [RB+1:0] trial;
		logic [RB+1:0] remx;
		always_comb begin
			trial = ((RB+2)'(res_q[s]) << (B + 1)) | ((RB+2)'(1) << (2 * B));
			remx  = (RB+2)'(rem_q[s]);
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[s+1] <= 1'b0;
			end else begin
				vld_q[s+1] <= vld_q[s];
			end
		end
		always_ff @(posedge clk) begin
			if (remx >= trial) begin
				rem_q[s+1] <= RB'(remx - trial);
				res_q[s+1] <= res_q[s] | (OUT_BITS'(1) << B);
			end else begin
				rem_q[s+1] <= rem_q[s];
				res_q[s+1] <= res_q[s];
			end
		end
	end

	assign out_valid = vld_q[OUT_BITS];
	assign root      = res_q[OUT_BITS];
endmodule

// ===== design/pdh_divider.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pdh_divider
// Pipelined restoring divider, one quotient bit per stage, saturated bucket.
// ---------------------------------------------------------------------------
module pdh_divider #(
	parameter int NUM_W    = 17,
	parameter int BKT_BITS = 6,
	parameter int NUM_BKT  = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic [NUM_W-1:0]       dividend,
	input  logic [15:0]            divisor,
	output logic                   out_valid,
	output logic [BKT_BITS-1:0]    bucket
);
	logic [NUM_W:0]   vld_q;
	logic [NUM_W-1:0] quo_q [NUM_W+1];
	logic [NUM_W-1:0] rem_q [NUM_W+1];

	always_comb begin
		vld_q[0] = in_valid;
		quo_q[0] = dividend;
		rem_q[0] = '0;
	end

	for (genvar s = 0; s < NUM_W; s++) begin : g_stage
		logic [NUM_W:0] shl;
		always_comb shl = {rem_q[s], quo_q[s][NUM_W-1]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[s+1] <= 1'b0;
			end else begin
				vld_q[s+1] <= vld_q[s];
			end
		end
		always_ff @(posedge clk) begin
			if (shl >= (NUM_W+1)'(divisor)) begin
				rem_q[s+1] <= NUM_W'(shl - (NUM_W+1)'(divisor));
				quo_q[s+1] <= {quo_q[s][NUM_W-2:0], 1'b1};
			end else begin
				rem_q[s+1] <= NUM_W'(shl);
				quo_q[s+1] <= {quo_q[s][NUM_W-2:0], 1'b0};
			end
		end
	end

	assign out_valid = vld_q[NUM_W];
	assign bucket = (quo_q[NUM_W] > NUM_W'(NUM_BKT - 1)) ? BKT_BITS'(NUM_BKT - 1)
		: BKT_BITS'(quo_q[NUM_W]);
endmodule

// ===== design/pdh_datapath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pdh_datapath
// Point store, pair walk, distance pipeline, histogram and result register.
// ---------------------------------------------------------------------------
module pdh_datapath
	import pdh_pkg::*;
#(
	parameter int MAX_POINTS = 1024,
	parameter int HIST_BINS  = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  pdh_cmd_t        cmd,
	output pdh_sts_t        sts,
	input  logic [15:0]     bucket_width,
	pdh_in_if.sink          pts,
	pdh_out_if.source       res
);
	`include "assert_macros.svh"

	localparam int PB   = $clog2(MAX_POINTS);
	localparam int CB   = $clog2(MAX_POINTS + 1);
	localparam int BB   = $clog2(HIST_BINS);
	localparam int SQB  = 2 * COORD_BITS + 2;
	localparam int RTB  = COORD_BITS + 1;
	localparam int LAT  = 2 + RTB + RTB + 1;
	localparam int LIMIT = (1 << CNT_BITS) - 1;

	logic [3*COORD_BITS-1:0] mem_a [MAX_POINTS];
	logic [3*COORD_BITS-1:0] mem_b [MAX_POINTS];
	logic [CB-1:0] count_q;
	logic [PB-1:0] i_q, j_q;
	logic [3*COORD_BITS-1:0] pa_s1, pb_s1;
	logic v_s1, v_s2;
	logic [SQB-1:0] sq_s2;
	logic [LAT:0] inflight_q;
	logic sq_v, rt_v, bk_v;
	logic [RTB-1:0] root;
	logic [BB-1:0] bk;
	logic [CNT_BITS-1:0] hist_mem [HIST_BINS];
	logic [HIST_BINS-1:0] ok_q;
	logic [CNT_BITS-1:0] rd_q;
	logic okr_q;
	logic rd_en;
	logic [BB-1:0] raddr;
	logic hv_s1, hv_s2;
	logic [BB-1:0] hb_s1, hb_s2;
	logic [CNT_BITS-1:0] hw_s2;
	logic [CNT_BITS-1:0] cur_cnt;
	logic [CNT_BITS-1:0] base;
	logic [CNT_BITS-1:0] nv;
	logic [BB-1:0] dump_q;
	logic [15:0] wdiv;
	logic [3*COORD_BITS-1:0] wr_pt;
	logic issue;
	logic wr_en;

	assign wr_pt = {pts.x_coord[COORD_BITS-1:0], pts.y_coord[COORD_BITS-1:0],
		pts.z_coord[COORD_BITS-1:0]};
	assign issue = cmd.pair_step;
	assign wr_en = cmd.load && pts.valid && (count_q < CB'(MAX_POINTS));
	assign wdiv  = (bucket_width == 16'd0) ? 16'd1 : bucket_width;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_a[count_q[PB-1:0]] <= wr_pt;
			mem_b[count_q[PB-1:0]] <= wr_pt;
		end
		pa_s1 <= mem_a[i_q];
		pb_s1 <= mem_b[j_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			i_q     <= '0;
			j_q     <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			if (cmd.clr_cnt) begin
				count_q <= '0;
			end else if (wr_en) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.pair_init) begin
				i_q <= '0;
				j_q <= PB'(1);
			end else if (issue) begin
				if (CB'(j_q) + 1'b1 >= count_q) begin
					i_q <= i_q + 1'b1;
					j_q <= i_q + PB'(2);
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	function automatic logic [SQB-1:0] axis_sq(input logic [COORD_BITS-1:0] a,
		input logic [COORD_BITS-1:0] b);
		logic [COORD_BITS-1:0] d;
		d = (a > b) ? a - b : b - a;
		return SQB'(d) * SQB'(d);
	endfunction

	always_ff @(posedge clk) begin
		sq_s2 <= axis_sq(pa_s1[3*COORD_BITS-1 -: COORD_BITS], pb_s1[3*COORD_BITS-1 -: COORD_BITS])
			+ axis_sq(pa_s1[2*COORD_BITS-1 -: COORD_BITS], pb_s1[2*COORD_BITS-1 -: COORD_BITS])
			+ axis_sq(pa_s1[COORD_BITS-1:0], pb_s1[COORD_BITS-1:0]);
	end
	assign sq_v = v_s2;

	pdh_isqrt #(.IN_BITS(SQB), .OUT_BITS(RTB)) u_isqrt (
		.clk(clk), .arst_n(arst_n), .in_valid(sq_v), .radicand(sq_s2),
		.out_valid(rt_v), .root(root)
	);

	pdh_divider #(.NUM_W(RTB), .BKT_BITS(BB), .NUM_BKT(HIST_BINS)) u_div (
		.clk(clk), .arst_n(arst_n), .in_valid(rt_v), .dividend(root),
		.divisor(wdiv), .out_valid(bk_v), .bucket(bk)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= {inflight_q[LAT-1:0], issue};
		end
	end

	// histogram: registered read, update in the cycle after the read, forward back-to-back hits
	assign rd_en = bk_v || cmd.dump_init || cmd.dump_step;

	always_comb begin
		if (cmd.dump_init) begin
			raddr = '0;
		end else if (cmd.dump_step) begin
			raddr = res.last_bucket ? '0 : dump_q + BB'(1);
		end else begin
			raddr = bk;
		end
	end

	assign cur_cnt = okr_q ? rd_q : '0;
	assign base    = (hv_s2 && hb_s2 == hb_s1) ? hw_s2 : cur_cnt;
	assign nv      = (base == CNT_BITS'(LIMIT)) ? base : base + 1'b1;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= hist_mem[raddr];
		end
		if (hv_s1) begin
			hist_mem[hb_s1] <= nv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q   <= '0;
			okr_q  <= 1'b0;
			hv_s1  <= 1'b0;
			hv_s2  <= 1'b0;
			hb_s1  <= '0;
			hb_s2  <= '0;
			hw_s2  <= '0;
			dump_q <= '0;
		end else begin
			if (rd_en) begin
				okr_q <= ok_q[raddr];
			end
			hv_s1 <= bk_v;
			hb_s1 <= bk;
			hv_s2 <= hv_s1;
			hb_s2 <= hb_s1;
			hw_s2 <= nv;
			if (hv_s1) begin
				ok_q[hb_s1] <= 1'b1;
			end
			if (cmd.dump_init) begin
				dump_q <= '0;
			end else if (cmd.dump_step) begin
				ok_q[dump_q] <= 1'b0;
				dump_q <= dump_q + 1'b1;
			end
		end
	end

	assign res.bucket_index = IDX_BITS'(dump_q);
	assign res.bucket_count = cur_cnt;
	assign res.last_bucket  = (dump_q == BB'(HIST_BINS - 1));
	assign pts.ready = cmd.load;

	assign sts.pairs_none = (count_q < CB'(2));
	assign sts.pairs_done = (CB'(i_q) + CB'(2) >= count_q) && (CB'(j_q) + 1'b1 >= count_q);
	assign sts.pipe_empty = (inflight_q == '0) && !bk_v && !hv_s1;
	assign sts.dump_last  = res.last_bucket;

	`ASSERT_IMPL(a_no_dump_busy, clk, arst_n, cmd.dump_step, inflight_q == '0,
		"dump while pairs in flight")
	`ASSERT_IMPL(a_pair_bounds, clk, arst_n, issue, (i_q < j_q) && (CB'(j_q) < count_q),
		"pair index out of range")
	`ASSERT_NEXT(a_count_clear, clk, arst_n, cmd.clr_cnt, count_q == '0,
		"point count not cleared")
endmodule

// ===== design/pdh_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pdh_ctrl
// Sequencer: load points, walk pairs, drain pipeline, emit histogram.
// ---------------------------------------------------------------------------
module pdh_ctrl
	import pdh_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_last,
	input  logic     out_ready,
	input  pdh_sts_t sts,
	output pdh_cmd_t cmd,
	output logic     out_valid
);
	`include "assert_macros.svh"

	localparam logic [2:0] S_LOAD  = 3'd0;
	localparam logic [2:0] S_PAIR  = 3'd1;
	localparam logic [2:0] S_DRAIN = 3'd2;
	localparam logic [2:0] S_DUMP  = 3'd3;
	localparam logic [2:0] S_START = 3'd4;

	logic [2:0] state_q;

	always_comb begin
		cmd = '0;
		out_valid = 1'b0;
		unique case (state_q)
			S_LOAD: begin
				cmd.load = 1'b1;
			end
			S_START: begin
				cmd.pair_init = 1'b1;
			end
			S_PAIR: begin
				cmd.pair_step = !sts.pairs_none;
			end
			S_DRAIN: begin
				cmd.dump_init = sts.pipe_empty;
			end
			S_DUMP: begin
				out_valid = 1'b1;
				cmd.dump_step = out_ready;
				cmd.clr_cnt = out_ready && sts.dump_last;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			unique case (state_q)
				S_LOAD:  if (in_valid && in_last) state_q <= S_START;
				S_START: state_q <= S_PAIR;
				S_PAIR:  if (sts.pairs_none || sts.pairs_done) state_q <= S_DRAIN;
				S_DRAIN: if (sts.pipe_empty) state_q <= S_DUMP;
				S_DUMP:  if (out_ready && sts.dump_last) state_q <= S_LOAD;
				default: state_q <= S_LOAD;
			endcase
		end
	end

	`ASSERT_IMPL(a_one_phase, clk, arst_n, 1'b1,
		$countones({cmd.load, cmd.pair_step, cmd.dump_step}) <= 1, "overlapping phases")
	`ASSERT_NEXT(a_start_pair, clk, arst_n, state_q == S_START, state_q == S_PAIR,
		"start not followed by pair walk")
endmodule
